// ===== src/mmss_pkg.sv =====
// ----------------------------------------------------------------------------
// mmss_pkg
// Shared constants and controller/datapath handshake types for the maximum
// median subarray search block.
// ----------------------------------------------------------------------------
package mmss_pkg;

	localparam int DATA_W           = 16;
	localparam int LEN_W            = 13;
	localparam int MAX_ITEMS_DEF    = 4096;
	localparam int VALUE_BITS_DEF   = 16;
	localparam logic [LEN_W-1:0] MIN_LENGTH_RESET = LEN_W'(1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_wr;
		logic search_init;
		logic pass_init;
		logic issue;
		logic decide;
		logic out_load;
	} mmss_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic search_done;
		logic last_issue;
		logic out_busy;
	} mmss_status_t;

endpackage

// ===== src/max_median_subarray_search.sv =====
// ----------------------------------------------------------------------------
// max_median_subarray_search
// Largest median over all contiguous runs of at least min_length values.
// ----------------------------------------------------------------------------
// Values stream in one beat per cycle while loading, the final one marked
// by tlast; each value is stored in a MAX_ITEMS-deep memory (later values
// are dropped once it is full). After the final beat the block
// binary-searches the median threshold: each of up to VALUE_BITS+1 steps
// scans the n stored values once at one value per cycle through the
// memory's two read ports. The result beat carries the median in tdata
// and the found flag in tuser; it is held in an output register so that
// loading of the next sequence proceeds while it waits. min_length is
// written through the cfg channel; the user must do so only while idle,
// as the block itself does not enforce this.
module max_median_subarray_search
	import mmss_pkg::*;
#(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [15:0] value
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [15:0] best_median
	output logic [0:0]        m_tuser,   // [0] found
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LEN_W-1:0]  cfg_data   // [12:0] min_length
);

	logic [LEN_W-1:0] min_length_q;
	mmss_cmd_t        cmd;
	mmss_status_t     status;
	logic             found;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RESET;
		end else if (cfg_valid) begin
			min_length_q <= cfg_data;
		end
	end

	mmss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mmss_dp #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_value   (s_tdata),
		.min_length (min_length_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_median (m_tdata),
		.out_found  (found)
	);

	assign m_tuser = found;

endmodule

// ===== src/mmss_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmss_ctrl
// Sequencer: loads the sequence, then runs one scan of the stored values per
// threshold of the binary search and hands the result to the output stage.
// ----------------------------------------------------------------------------
module mmss_ctrl
	import mmss_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_last,
	output logic         in_ready,
	input  mmss_status_t status,
	output mmss_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_PASS,
		ST_RUN,
		ST_DRAIN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid && in_last) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_PASS;
				end
				ST_PASS: begin
					state_q <= status.search_done ? ST_FINISH : ST_RUN;
				end
				ST_RUN: begin
					if (status.last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_PASS;
				end
				ST_FINISH: begin
					if (!status.out_busy) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_LOAD);

	always_comb begin
		cmd             = '0;
		cmd.load_wr     = (state_q == ST_LOAD) && in_valid;
		cmd.search_init = (state_q == ST_START);
		cmd.pass_init   = (state_q == ST_PASS) && !status.search_done;
		cmd.issue       = (state_q == ST_RUN);
		cmd.decide      = (state_q == ST_DECIDE);
		cmd.out_load    = (state_q == ST_FINISH) && !status.out_busy;
	end

endmodule

// ===== src/mmss_dp.sv =====
// ----------------------------------------------------------------------------
// mmss_dp
// Datapath: value memory with one write and two read ports, the leading and
// trailing prefix sums, the trailing minimum, the search bounds and the
// result register.
// ----------------------------------------------------------------------------
module mmss_dp
	import mmss_pkg::*;
#(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mmss_cmd_t         cmd,
	output mmss_status_t      status,
	input  logic [DATA_W-1:0] in_value,
	input  logic [LEN_W-1:0]  min_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_median,
	output logic              out_found
);

	localparam int W     = VALUE_BITS;
	localparam int AW    = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int EW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int PW    = CNT_W + 1;
	localparam logic [W-1:0]         VALUE_MASK = '1;
	localparam logic signed [PW-1:0] STEP_UP    = PW'(1);
	localparam logic signed [PW-1:0] STEP_DOWN  = '1;

	logic [W-1:0]     mem [MAX_ITEMS];
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    j_q;
	logic [W:0]       low_q, high_q;
	logic [W-1:0]     mid_q, best_q;
	logic             stop_q, found_q, ok_q;
	logic signed [PW-1:0] p_q, lp_q, min_q;
	logic [W-1:0]     lead_s1, lag_s1;
	logic             rd_s1, lag_en_s1, chk_en_s1;
	logic             out_valid_q;
	logic [DATA_W-1:0] out_median_q;
	logic             out_found_q;

	logic [EW-1:0]    k_w, j_w, n_w;
	logic             lag_en, chk_en;
	logic [AW-1:0]    lag_addr;
	logic [W+1:0]     bound_sum;
	logic [W-1:0]     mid;
	logic signed [PW-1:0] p_next, lp_next, min_next;

	// A zero minimum length behaves as one.
	assign k_w = (min_length == '0) ? EW'(1) : EW'(min_length);
	assign j_w = EW'(j_q);
	assign n_w = EW'(count_q);

	assign lag_en   = (j_w >= k_w);
	assign chk_en   = (j_w + EW'(1) >= k_w);
	assign lag_addr = AW'(j_w - k_w);

	assign bound_sum = (W+2)'(low_q) + (W+2)'(high_q);
	assign mid       = W'(bound_sum >> 1);

	assign status.search_done = stop_q || (low_q > high_q);
	assign status.last_issue  = (j_w + EW'(1) == n_w);
	assign status.out_busy    = out_valid_q && !out_ready;

	// Memory: written while loading, read at the leading and trailing index.
	always_ff @(posedge clk) begin
		if (cmd.load_wr && (count_q < CNT_W'(MAX_ITEMS))) begin
			mem[AW'(count_q)] <= W'(in_value);
		end
		if (cmd.issue) begin
			lead_s1 <= mem[j_q];
			lag_s1  <= mem[lag_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_s1     <= 1'b0;
			lag_en_s1 <= 1'b0;
			chk_en_s1 <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				count_q <= '0;
			end else if (cmd.load_wr && (count_q < CNT_W'(MAX_ITEMS))) begin
				count_q <= count_q + CNT_W'(1);
			end
			rd_s1     <= cmd.issue;
			lag_en_s1 <= cmd.issue && lag_en;
			chk_en_s1 <= cmd.issue && chk_en;
		end
	end

	// One scan step: extend the leading prefix, advance the trailing prefix,
	// keep its minimum and look for a window with a positive sum.
	always_comb begin
		p_next   = p_q + ((lead_s1 >= mid_q) ? STEP_UP : STEP_DOWN);
		lp_next  = lag_en_s1 ? (lp_q + ((lag_s1 >= mid_q) ? STEP_UP : STEP_DOWN)) : lp_q;
		min_next = (lp_next < min_q) ? lp_next : min_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			low_q   <= '0;
			high_q  <= '0;
			mid_q   <= '0;
			best_q  <= '0;
			stop_q  <= 1'b0;
			found_q <= 1'b0;
			ok_q    <= 1'b0;
			p_q     <= '0;
			lp_q    <= '0;
			min_q   <= '0;
		end else begin
			if (cmd.search_init) begin
				low_q   <= '0;
				high_q  <= (W+1)'(VALUE_MASK);
				best_q  <= '0;
				found_q <= (k_w <= n_w);
				stop_q  <= !(k_w <= n_w);
			end
			if (cmd.pass_init) begin
				mid_q <= mid;
				j_q   <= '0;
				p_q   <= '0;
				lp_q  <= '0;
				min_q <= '0;
				ok_q  <= 1'b0;
			end
			if (cmd.issue) begin
				j_q <= j_q + AW'(1);
			end
			if (rd_s1) begin
				p_q   <= p_next;
				lp_q  <= lp_next;
				min_q <= min_next;
				if (chk_en_s1 && (p_next > min_next)) begin
					ok_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				if (ok_q) begin
					best_q <= mid_q;
					low_q  <= (W+1)'(mid_q) + (W+1)'(1);
				end else if (mid_q == '0) begin
					stop_q <= 1'b1;
				end else begin
					high_q <= (W+1)'(mid_q) - (W+1)'(1);
				end
			end
		end
	end

	// Result register: a finished beat waits here while loading resumes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_median_q <= DATA_W'(best_q);
			out_found_q  <= found_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_median = out_median_q;
	assign out_found  = out_found_q;

endmodule
